// ===== hw/rtl/grp_pkg.sv =====
package grp_pkg;

   localparam int MaxSheets = 16;
   localparam int MaxFree = 32;
   localparam int SheetBits = $clog2(MaxSheets);
   localparam int SlotBits = $clog2(MaxFree);
   localparam int CountBits = $clog2(MaxFree + 1);
   localparam int OpenBits = $clog2(MaxSheets + 1);
   localparam int AddrBits = SheetBits + SlotBits;
   localparam int DimBits = 10;
   localparam int AreaBits = 24;
   localparam logic [AreaBits-1:0] AreaMax = {AreaBits{1'b1}};

   localparam logic [DimBits-1:0] SheetDimReset = 10'd50;

   localparam logic [0:0] RegSheetLength = 1'b0;
   localparam logic [0:0] RegSheetHeight = 1'b1;

   localparam logic [1:0] StatPlaced = 2'd0;
   localparam logic [1:0] StatNewSheet = 2'd1;
   localparam logic [1:0] StatTooLarge = 2'd2;
   localparam logic [1:0] StatNoSheet = 2'd3;

   typedef struct packed {
      logic [DimBits-1:0] len;
      logic [DimBits-1:0] hgt;
   } rect_type;

endpackage

// ===== hw/rtl/guillotine_rect_packer_unit.sv =====
// Each request scans the free entries of the open sheets in order, passing over exhausted sheets and
// opening a new sheet if none fits, then moves the later entries down one slot and appends remainders;
// a zero-size piece goes straight to the result as rejected.
// Throughput: one request at a time; the next is taken in the cycle after the result is loaded,
// and a result that waits on rsp_stall holds the block.
// Reset: synchronous, active high; clears counts, totals and sheet size (50 x 50), not the memory.
module guillotine_rect_packer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [grp_pkg::DimBits-1:0]     req_piece_length,
   input  logic [grp_pkg::DimBits-1:0]     req_piece_height,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [3:0]                      rsp_sheet_index,
   output logic                            rsp_remainder_lost,
   output logic [4:0]                      rsp_sheets_used,
   output logic [grp_pkg::AreaBits-1:0]    rsp_area_used_total,
   output logic [grp_pkg::AreaBits-1:0]    rsp_waste_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [grp_pkg::DimBits-1:0]     csr_data
);

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StSheet = 4'd1;
   localparam logic [3:0] StRead = 4'd2;
   localparam logic [3:0] StCheck = 4'd3;
   localparam logic [3:0] StShift = 4'd4;
   localparam logic [3:0] StShiftW = 4'd5;
   localparam logic [3:0] StPush1 = 4'd6;
   localparam logic [3:0] StPush2 = 4'd7;
   localparam logic [3:0] StNewSheet = 4'd8;
   localparam logic [3:0] StTotals = 4'd9;
   localparam logic [3:0] StOut = 4'd10;

   localparam int SB = grp_pkg::SheetBits;
   localparam int CB = grp_pkg::CountBits;
   localparam int OB = grp_pkg::OpenBits;
   localparam int DB = grp_pkg::DimBits;
   localparam int AB = grp_pkg::AreaBits;

   // Free-rectangle memory, one entry per sheet slot.
   grp_pkg::rect_type free_mem [0:(1 << grp_pkg::AddrBits)-1];
   grp_pkg::rect_type rd_data_ff;
   logic [grp_pkg::AddrBits-1:0] rd_addr, wr_addr;
   logic wr_en;
   grp_pkg::rect_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= free_mem[rd_addr];
   end

   logic [3:0] state_ff, state_in;
   logic [DB-1:0] len_cfg_ff, len_cfg_in, hgt_cfg_ff, hgt_cfg_in;
   logic [CB-1:0] count_ff [grp_pkg::MaxSheets];
   logic [OB-1:0] open_ff, open_in;
   logic [AB-1:0] placed_ff, placed_in, opened_ff, opened_in;
   logic [DB-1:0] pl_ff, pl_in, ph_ff, ph_in;
   logic [SB-1:0] sheet_ff, sheet_in;
   logic [CB-1:0] slot_ff, slot_in;
   grp_pkg::rect_type hit_ff, hit_in;
   logic lost_ff, lost_in;
   logic [1:0] stat_ff, stat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] o_stat_ff, o_stat_in;
   logic [3:0] o_idx_ff, o_idx_in;
   logic o_lost_ff, o_lost_in;
   logic [4:0] o_used_ff, o_used_in;
   logic [AB-1:0] o_area_ff, o_area_in, o_waste_ff, o_waste_in;
   logic cnt_we;
   logic [CB-1:0] cnt_wdata;
   logic [SB-1:0] cnt_wsheet;

   logic [CB-1:0] cur_count;
   logic [2*DB-1:0] area_prod;
   logic [AB:0] area_sum;
   logic [DB-1:0] rem_len, rem_hgt;

   assign cur_count = count_ff[sheet_ff];
   assign rem_len = hit_ff.len - pl_ff;
   assign rem_hgt = hit_ff.hgt - ph_ff;

   assign req_stall = (state_ff != StIdle);
   assign csr_ready = (state_ff == StIdle) && !rsp_valid_ff;

   // Sequencer: scan, open a new sheet when needed, compact, append remainders, update totals.
   always_comb begin
      state_in = state_ff;
      len_cfg_in = len_cfg_ff;
      hgt_cfg_in = hgt_cfg_ff;
      open_in = open_ff;
      placed_in = placed_ff;
      opened_in = opened_ff;
      pl_in = pl_ff;
      ph_in = ph_ff;
      sheet_in = sheet_ff;
      slot_in = slot_ff;
      hit_in = hit_ff;
      lost_in = lost_ff;
      stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_stat_in = o_stat_ff;
      o_idx_in = o_idx_ff;
      o_lost_in = o_lost_ff;
      o_used_in = o_used_ff;
      o_area_in = o_area_ff;
      o_waste_in = o_waste_ff;
      rd_addr = {sheet_ff, slot_ff[grp_pkg::SlotBits-1:0]};
      wr_en = 1'b0;
      wr_addr = {sheet_ff, slot_ff[grp_pkg::SlotBits-1:0]};
      wr_data = rd_data_ff;
      cnt_we = 1'b0;
      cnt_wdata = cur_count;
      cnt_wsheet = sheet_ff;
      area_prod = '0;
      area_sum = '0;

      if (csr_valid && csr_ready) begin
         if (csr_index == grp_pkg::RegSheetLength) begin
            len_cfg_in = csr_data;
         end else begin
            hgt_cfg_in = csr_data;
         end
      end

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               pl_in = req_piece_length;
               ph_in = req_piece_height;
               sheet_in = '0;
               slot_in = '0;
               lost_in = 1'b0;
               if (req_piece_length == '0 || req_piece_height == '0) begin
                  stat_in = grp_pkg::StatTooLarge;
                  state_in = StOut;
               end else begin
                  state_in = StSheet;
               end
            end
         end
         StSheet: begin
            // Decide whether the current sheet is open and has entries left.
            if ({1'b0, sheet_ff} >= open_ff || open_ff == '0) begin
               state_in = StNewSheet;
            end else if (slot_ff >= cur_count) begin
               slot_in = '0;
               if (sheet_ff == SB'(grp_pkg::MaxSheets - 1)) begin
                  state_in = StNewSheet;
               end else begin
                  sheet_in = sheet_ff + 1'b1;
               end
            end else begin
               state_in = StRead;
            end
         end
         StRead: begin
            state_in = StCheck;
         end
         StCheck: begin
            if (rd_data_ff.len >= pl_ff && rd_data_ff.hgt >= ph_ff) begin
               hit_in = rd_data_ff;
               stat_in = grp_pkg::StatPlaced;
               state_in = StShift;
            end else begin
               slot_in = slot_ff + 1'b1;
               state_in = StSheet;
            end
         end
         StShift: begin
            // Read the next entry to move down by one slot.
            if (slot_ff + 1'b1 >= cur_count) begin
               cnt_we = 1'b1;
               cnt_wdata = cur_count - 1'b1;
               state_in = StPush1;
            end else begin
               rd_addr = {sheet_ff, slot_in[grp_pkg::SlotBits-1:0] + 1'b1};
               state_in = StShiftW;
            end
         end
         StShiftW: begin
            wr_en = 1'b1;
            slot_in = slot_ff + 1'b1;
            state_in = StShift;
         end
         StPush1: begin
            if (rem_len != '0) begin
               if (cur_count >= CB'(grp_pkg::MaxFree)) begin
                  lost_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = {sheet_ff, cur_count[grp_pkg::SlotBits-1:0]};
                  wr_data = '{len: rem_len, hgt: hit_ff.hgt};
                  cnt_we = 1'b1;
                  cnt_wdata = cur_count + 1'b1;
               end
            end
            state_in = StPush2;
         end
         StPush2: begin
            if (rem_hgt != '0) begin
               if (cur_count >= CB'(grp_pkg::MaxFree)) begin
                  lost_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = {sheet_ff, cur_count[grp_pkg::SlotBits-1:0]};
                  wr_data = '{len: pl_ff, hgt: rem_hgt};
                  cnt_we = 1'b1;
                  cnt_wdata = cur_count + 1'b1;
               end
            end
            state_in = StTotals;
         end
         StNewSheet: begin
            if (pl_ff > len_cfg_ff || ph_ff > hgt_cfg_ff) begin
               stat_in = grp_pkg::StatTooLarge;
               state_in = StOut;
            end else if (open_ff >= OB'(grp_pkg::MaxSheets)) begin
               stat_in = grp_pkg::StatNoSheet;
               state_in = StOut;
            end else begin
               // The fresh sheet's single rectangle goes straight to placement.
               sheet_in = open_ff[SB-1:0];
               cnt_we = 1'b1;
               cnt_wsheet = open_ff[SB-1:0];
               cnt_wdata = CB'(1);
               slot_in = '0;
               hit_in = '{len: len_cfg_ff, hgt: hgt_cfg_ff};
               open_in = open_ff + 1'b1;
               area_prod = len_cfg_ff * hgt_cfg_ff;
               area_sum = {1'b0, opened_ff} + (AB+1)'(area_prod);
               opened_in = area_sum[AB] ? grp_pkg::AreaMax : area_sum[AB-1:0];
               stat_in = grp_pkg::StatNewSheet;
               state_in = StShift;
            end
         end
         StTotals: begin
            area_prod = pl_ff * ph_ff;
            area_sum = {1'b0, placed_ff} + (AB+1)'(area_prod);
            placed_in = area_sum[AB] ? grp_pkg::AreaMax : area_sum[AB-1:0];
            state_in = StOut;
         end
         StOut: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_stat_in = stat_ff;
               o_idx_in = (stat_ff == grp_pkg::StatPlaced || stat_ff == grp_pkg::StatNewSheet)
                  ? 4'(sheet_ff) : 4'd0;
               o_lost_in = (stat_ff == grp_pkg::StatPlaced || stat_ff == grp_pkg::StatNewSheet)
                  ? lost_ff : 1'b0;
               o_used_in = 5'(open_ff);
               o_area_in = placed_ff;
               o_waste_in = (opened_ff > placed_ff) ? opened_ff - placed_ff : '0;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         len_cfg_ff <= grp_pkg::SheetDimReset;
         hgt_cfg_ff <= grp_pkg::SheetDimReset;
         open_ff <= '0;
         placed_ff <= '0;
         opened_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < grp_pkg::MaxSheets; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         len_cfg_ff <= len_cfg_in;
         hgt_cfg_ff <= hgt_cfg_in;
         open_ff <= open_in;
         placed_ff <= placed_in;
         opened_ff <= opened_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            count_ff[cnt_wsheet] <= cnt_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pl_ff <= pl_in;
      ph_ff <= ph_in;
      sheet_ff <= sheet_in;
      slot_ff <= slot_in;
      hit_ff <= hit_in;
      lost_ff <= lost_in;
      stat_ff <= stat_in;
      o_stat_ff <= o_stat_in;
      o_idx_ff <= o_idx_in;
      o_lost_ff <= o_lost_in;
      o_used_ff <= o_used_in;
      o_area_ff <= o_area_in;
      o_waste_ff <= o_waste_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = o_stat_ff;
   assign rsp_sheet_index = o_idx_ff;
   assign rsp_remainder_lost = o_lost_ff;
   assign rsp_sheets_used = o_used_ff;
   assign rsp_area_used_total = o_area_ff;
   assign rsp_waste_total = o_waste_ff;

   // The number of open sheets never exceeds the sheet limit.
   assert property (@(posedge clock) disable iff (reset)
      open_ff <= OB'(grp_pkg::MaxSheets))
      else $error("open sheet count exceeds limit");

   // A rejected request never reports a sheet or a lost remainder.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == grp_pkg::StatTooLarge || rsp_status == grp_pkg::StatNoSheet)
      |-> rsp_sheet_index == 4'd0 && !rsp_remainder_lost)
      else $error("rejected request reports placement");

   // Opening a sheet raises the open count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == StNewSheet && state_in == StShift |=> open_ff == $past(open_ff) + 1'b1)
      else $error("sheet open count not advanced");

   // Configuration is only taken while no request is in flight.
   assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> state_ff == StIdle)
      else $error("configuration accepted while busy");

endmodule
